// ===== sv/tcpq_pkg.sv =====
// Package for the two-class pushout queue.
// Holds operation, status, register index and state codes plus fixed field widths.
// No dependencies.
package tcpq_pkg;

	localparam int SIZE_W    = 16;
	localparam int TOS_W     = 8;
	localparam int BYTES_W   = 24;
	localparam int MAXPKT_W  = 8;
	localparam int CFG_IDX_W = 2;
	localparam int CLASS_SHIFT = 2;

	localparam logic [MAXPKT_W-1:0] MAX_PACKETS_RST = 8'd100;
	localparam logic [BYTES_W-1:0]  MAX_BYTES_RST   = 24'd6553500;

	typedef enum logic [1:0] {
		OP_ENQ  = 2'd0,
		OP_DEQ  = 2'd1,
		OP_PEEK = 2'd2,
		OP_NONE = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_ACCEPTED = 3'd0,
		ST_PUSHOUT  = 3'd1,
		ST_DROPPED  = 3'd2,
		ST_DEQUEUED = 3'd3,
		ST_EMPTY    = 3'd4,
		ST_PEEKED   = 3'd5
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_LIMIT_MODE  = 2'd0,
		CFG_MAX_PACKETS = 2'd1,
		CFG_MAX_BYTES   = 2'd2,
		CFG_PRIORITY_EN = 2'd3
	} cfg_idx_t;

	typedef enum logic [1:0] {
		FSM_IDLE = 2'd0,
		FSM_READ = 2'd1,
		FSM_EXEC = 2'd2
	} fsm_t;

endpackage

// ===== sv/tcpq_ram.sv =====
// Simple dual-port descriptor store with one write port and a registered read port.
// Used once per class by the two-class pushout queue; no package dependencies.
module tcpq_ram #(
	parameter int DEPTH = 128,
	parameter int WIDTH = 32,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== sv/two_class_pushout_queue.sv =====
// Top level of the two-class packet descriptor queue with priority pushout.
// Uses tcpq_pkg for codes and widths and tcpq_ram for the two descriptor stores.
//
// Channel | Direction | Handshake             | Word
// in      | input     | in_valid / in_stall   | op, pkt_handle, pkt_size, tos_byte
// out     | output    | out_valid / out_stall | status, out_handle, out_size, bytes_held
// cfg     | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// Each word goes through accept, a store read at the head pointers, then execute.
// The registered read port of the descriptor stores is why the store read is a step of its own.
// A finished result sits in an output register, so the next word is accepted while it waits.
// Execute holds while the output register is full and stalled.
// Reset empties both queues at once; the stores need no clearing pass.
module two_class_pushout_queue
	import tcpq_pkg::*;
#(
	parameter int QUEUE_DEPTH = 128,
	parameter int HANDLE_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [1:0]             op,
	input  logic [HANDLE_BITS-1:0] pkt_handle,
	input  logic [SIZE_W-1:0]      pkt_size,
	input  logic [TOS_W-1:0]       tos_byte,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [2:0]             status,
	output logic [HANDLE_BITS-1:0] out_handle,
	output logic [SIZE_W-1:0]      out_size,
	output logic [BYTES_W-1:0]     bytes_held,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [BYTES_W-1:0]     cfg_data
);

	localparam int PTR_W   = $clog2(QUEUE_DEPTH);
	localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
	localparam int ENTRY_W = HANDLE_BITS + SIZE_W;
	localparam int CMP_W   = (CNT_W + 1 > MAXPKT_W) ? CNT_W + 1 : MAXPKT_W;

	fsm_t state_q, state_d;
	logic exec_en;

	logic                   limit_mode_q;
	logic [MAXPKT_W-1:0]    max_packets_q;
	logic [BYTES_W-1:0]     max_bytes_q;
	logic                   priority_en_q;

	op_t                    op_q;
	logic [HANDLE_BITS-1:0] handle_q;
	logic [SIZE_W-1:0]      size_q;
	logic [TOS_W-1:0]       tos_q;

	logic [CNT_W-1:0]   hcnt_q, hcnt_d, lcnt_q, lcnt_d;
	logic [PTR_W-1:0]   hrd_q, hrd_d, lrd_q, lrd_d;
	logic [BYTES_W-1:0] total_q, total_d;

	logic                   out_valid_q;
	status_t                status_q, status_d;
	logic [HANDLE_BITS-1:0] out_handle_q, out_handle_d;
	logic [SIZE_W-1:0]      out_size_q, out_size_d;
	logic                   res_valid;

	logic               h_we, l_we;
	logic [PTR_W-1:0]   h_waddr, l_waddr;
	logic [ENTRY_W-1:0] wdata, h_rdata, l_rdata;

	logic [HANDLE_BITS-1:0] h_head_handle, l_head_handle;
	logic [SIZE_W-1:0]      h_head_size, l_head_size;
	logic [PTR_W-1:0]       hrd_next, lrd_next;
	logic [CNT_W:0]         hsum, lsum;
	logic [BYTES_W:0]       enq_sum, po_sum;
	logic [BYTES_W-1:0]     total_less_victim;
	logic                   high_cls, tgt_full, over;

	// Control sequence.
	always_comb begin
		state_d = state_q;
		case (state_q)
			FSM_IDLE: begin
				if (in_valid) begin
					state_d = FSM_READ;
				end
			end
			FSM_READ: state_d = FSM_EXEC;
			FSM_EXEC: begin
				if (exec_en) begin
					state_d = FSM_IDLE;
				end
			end
			default: state_d = FSM_IDLE;
		endcase
	end

	always_comb begin
		in_stall = 1'b1;
		exec_en  = 1'b0;
		case (state_q)
			FSM_IDLE: in_stall = 1'b0;
			FSM_EXEC: exec_en = !(out_valid_q && out_stall);
			default: begin
				in_stall = 1'b1;
				exec_en  = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FSM_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Configuration registers.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_mode_q  <= 1'b0;
			max_packets_q <= MAX_PACKETS_RST;
			max_bytes_q   <= MAX_BYTES_RST;
			priority_en_q <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_idx_t'(cfg_index))
				CFG_LIMIT_MODE:  limit_mode_q  <= cfg_data[0];
				CFG_MAX_PACKETS: max_packets_q <= cfg_data[MAXPKT_W-1:0];
				CFG_MAX_BYTES:   max_bytes_q   <= cfg_data;
				CFG_PRIORITY_EN: priority_en_q <= cfg_data[0];
				default: limit_mode_q <= limit_mode_q;
			endcase
		end
	end

	// Accepted word.
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			op_q     <= op_t'(op);
			handle_q <= pkt_handle;
			size_q   <= pkt_size;
			tos_q    <= tos_byte;
		end
	end

	tcpq_ram #(.DEPTH(QUEUE_DEPTH), .WIDTH(ENTRY_W)) u_high_ram (
		.clk   (clk),
		.we    (h_we),
		.waddr (h_waddr),
		.wdata (wdata),
		.raddr (hrd_q),
		.rdata (h_rdata)
	);

	tcpq_ram #(.DEPTH(QUEUE_DEPTH), .WIDTH(ENTRY_W)) u_low_ram (
		.clk   (clk),
		.we    (l_we),
		.waddr (l_waddr),
		.wdata (wdata),
		.raddr (lrd_q),
		.rdata (l_rdata)
	);

	assign wdata         = {handle_q, size_q};
	assign h_head_handle = h_rdata[ENTRY_W-1 -: HANDLE_BITS];
	assign h_head_size   = h_rdata[SIZE_W-1:0];
	assign l_head_handle = l_rdata[ENTRY_W-1 -: HANDLE_BITS];
	assign l_head_size   = l_rdata[SIZE_W-1:0];

	assign hsum = (CNT_W+1)'(hrd_q) + (CNT_W+1)'(hcnt_q);
	assign lsum = (CNT_W+1)'(lrd_q) + (CNT_W+1)'(lcnt_q);
	assign h_waddr = (hsum >= (CNT_W+1)'(QUEUE_DEPTH)) ?
		PTR_W'(hsum - (CNT_W+1)'(QUEUE_DEPTH)) : PTR_W'(hsum);
	assign l_waddr = (lsum >= (CNT_W+1)'(QUEUE_DEPTH)) ?
		PTR_W'(lsum - (CNT_W+1)'(QUEUE_DEPTH)) : PTR_W'(lsum);

	assign hrd_next = (hrd_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : hrd_q + PTR_W'(1);
	assign lrd_next = (lrd_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : lrd_q + PTR_W'(1);

	assign high_cls = !priority_en_q || ((tos_q >> CLASS_SHIFT) == '0);
	assign tgt_full = high_cls ? (hcnt_q >= CNT_W'(QUEUE_DEPTH))
		: (lcnt_q >= CNT_W'(QUEUE_DEPTH));

	assign enq_sum           = {1'b0, total_q} + (BYTES_W+1)'(size_q);
	assign total_less_victim = total_q - BYTES_W'(l_head_size);
	assign po_sum            = {1'b0, total_less_victim} + (BYTES_W+1)'(size_q);

	assign over = limit_mode_q ? (enq_sum >= {1'b0, max_bytes_q})
		: ((CMP_W'(hcnt_q) + CMP_W'(lcnt_q)) >= CMP_W'(max_packets_q));

	// Execute step: one read-modify-write of the queue state.
	always_comb begin
		hcnt_d       = hcnt_q;
		lcnt_d       = lcnt_q;
		hrd_d        = hrd_q;
		lrd_d        = lrd_q;
		total_d      = total_q;
		h_we         = 1'b0;
		l_we         = 1'b0;
		status_d     = ST_DROPPED;
		out_handle_d = '0;
		out_size_d   = '0;
		res_valid    = 1'b1;
		case (op_q)
			OP_ENQ: begin
				if (tgt_full) begin
					status_d = ST_DROPPED;
				end else if (over) begin
					if (high_cls && (lcnt_q != '0) && !po_sum[BYTES_W]) begin
						lrd_d        = lrd_next;
						lcnt_d       = lcnt_q - CNT_W'(1);
						h_we         = 1'b1;
						hcnt_d       = hcnt_q + CNT_W'(1);
						total_d      = po_sum[BYTES_W-1:0];
						status_d     = ST_PUSHOUT;
						out_handle_d = l_head_handle;
						out_size_d   = l_head_size;
					end
				end else if (!enq_sum[BYTES_W]) begin
					total_d  = enq_sum[BYTES_W-1:0];
					status_d = ST_ACCEPTED;
					if (high_cls) begin
						h_we   = 1'b1;
						hcnt_d = hcnt_q + CNT_W'(1);
					end else begin
						l_we   = 1'b1;
						lcnt_d = lcnt_q + CNT_W'(1);
					end
				end
			end
			OP_DEQ, OP_PEEK: begin
				if (hcnt_q != '0) begin
					out_handle_d = h_head_handle;
					out_size_d   = h_head_size;
					if (op_q == OP_DEQ) begin
						hrd_d   = hrd_next;
						hcnt_d  = hcnt_q - CNT_W'(1);
						total_d = total_q - BYTES_W'(h_head_size);
					end
				end else if (lcnt_q != '0) begin
					out_handle_d = l_head_handle;
					out_size_d   = l_head_size;
					if (op_q == OP_DEQ) begin
						lrd_d   = lrd_next;
						lcnt_d  = lcnt_q - CNT_W'(1);
						total_d = total_q - BYTES_W'(l_head_size);
					end
				end
				if ((hcnt_q == '0) && (lcnt_q == '0)) begin
					status_d = ST_EMPTY;
				end else if (op_q == OP_DEQ) begin
					status_d = ST_DEQUEUED;
				end else begin
					status_d = ST_PEEKED;
				end
			end
			default: res_valid = 1'b0;
		endcase
		if (!exec_en) begin
			h_we = 1'b0;
			l_we = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hcnt_q  <= '0;
			lcnt_q  <= '0;
			hrd_q   <= '0;
			lrd_q   <= '0;
			total_q <= '0;
		end else if (exec_en) begin
			hcnt_q  <= hcnt_d;
			lcnt_q  <= lcnt_d;
			hrd_q   <= hrd_d;
			lrd_q   <= lrd_d;
			total_q <= total_d;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (exec_en && res_valid) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (exec_en && res_valid) begin
			status_q     <= status_d;
			out_handle_q <= out_handle_d;
			out_size_q   <= out_size_d;
		end
	end

	logic [BYTES_W-1:0] held_q;

	always_ff @(posedge clk) begin
		if (exec_en && res_valid) begin
			held_q <= total_d;
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign out_handle = out_handle_q;
	assign out_size   = out_size_q;
	assign bytes_held = held_q;

endmodule
